// ===== sv/fwr_pkg.sv =====
// ----------------------------------------------------------------------------
// fwr_pkg
// shared types and constants of the fifo with removal at an index
// ----------------------------------------------------------------------------
package fwr_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int ELEM_WIDTH_DEF = 32;

    localparam int OP_W    = 2;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 4;

    localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
    localparam logic [OP_W-1:0] OP_DISCARD = 2'd2;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

endpackage

// ===== sv/fifo_with_remove_at_index.sv =====
// ----------------------------------------------------------------------------
// fifo_with_remove_at_index
// bounded fifo of signed elements with enqueue, dequeue and discard at index
// ----------------------------------------------------------------------------
// the input channel (s_) carries one request: enqueue s_value at the tail,
// dequeue the head, or discard the element at s_position counted from the
// head; later elements shift down to close the gap. op code 3 is a no-op.
// every request returns one result on the m_ channel: the head element after
// the request (zero when empty), the count, an empty flag and a status.
// refused requests (full, empty, position not below count) change nothing.
// the elements live in a shifting register line, slot zero is the head; a
// request is applied in the cycle it is accepted and its result appears in
// the output register on the next cycle, and one request can be taken every
// cycle while the receiver does not stall.
// s_ready is high while the output register is empty or being drained, so a
// stalled receiver stops new requests after one pending result.
// reset (aresetn low, synchronous) empties the queue and drops any pending
// result; element slots are not cleared.
// ----------------------------------------------------------------------------
module fifo_with_remove_at_index #(
    parameter int DEPTH      = fwr_pkg::DEPTH_DEF,
    parameter int ELEM_WIDTH = fwr_pkg::ELEM_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [fwr_pkg::OP_W-1:0]             s_op,
    input  logic signed [fwr_pkg::VALUE_W-1:0]   s_value,
    input  logic [fwr_pkg::POS_W-1:0]            s_position,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [fwr_pkg::VALUE_W-1:0]   m_head_value,
    output logic [$clog2(DEPTH+1)-1:0]           m_count,
    output logic                                 m_is_empty,
    output fwr_pkg::status_t                     m_status
);
    import fwr_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [ELEM_WIDTH-1:0]  entries_reg [DEPTH];
    logic [ELEM_WIDTH-1:0]  entries_next [DEPTH];
    logic [CNT_W-1:0]       occupancy_reg;
    logic [CNT_W-1:0]       occupancy_next;

    logic                      out_valid_reg;
    logic signed [VALUE_W-1:0] head_reg;
    logic signed [VALUE_W-1:0] head_next;
    logic [CNT_W-1:0]          count_reg;
    logic                      empty_reg;
    status_t                   status_reg;
    status_t                   status_next;

    logic                   accept;
    logic                   is_full;
    logic                   is_zero;
    logic [CMP_W-1:0]       pos_ext;
    logic [CMP_W-1:0]       occ_ext;
    logic                   do_enq;
    logic                   do_remove;
    logic signed [63:0]     value_ext;
    logic [ELEM_WIDTH-1:0]  elem_in;
    logic signed [63:0]     head_ext;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign is_full   = (occupancy_reg == CNT_W'(DEPTH));
    assign is_zero   = (occupancy_reg == '0);
    assign pos_ext   = CMP_W'(s_position);
    assign occ_ext   = CMP_W'(occupancy_reg);
    assign value_ext = 64'(s_value);
    assign elem_in   = value_ext[ELEM_WIDTH-1:0];

    // decode and status
    always_comb begin
        do_enq      = 1'b0;
        do_remove   = 1'b0;
        status_next = ST_OK;
        case (s_op)
            OP_ENQUEUE: begin
                if (is_full) begin
                    status_next = ST_FULL;
                end else begin
                    do_enq = 1'b1;
                end
            end
            OP_DEQUEUE: begin
                if (is_zero) begin
                    status_next = ST_EMPTY;
                end else begin
                    do_remove = 1'b1;
                end
            end
            OP_DISCARD: begin
                if (is_zero) begin
                    status_next = ST_EMPTY;
                end else if (pos_ext >= occ_ext) begin
                    status_next = ST_RANGE;
                end else begin
                    do_remove = 1'b1;
                end
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
    end

    // next contents of the shift line
    always_comb begin
        logic [CMP_W-1:0] rm_pos;
        rm_pos = (s_op == OP_DEQUEUE) ? '0 : pos_ext;
        for (int i = 0; i < DEPTH; i++) begin
            entries_next[i] = entries_reg[i];
            if (do_remove && (CMP_W'(i) >= rm_pos) && (i < DEPTH - 1)) begin
                entries_next[i] = entries_reg[(i + 1) % DEPTH];
            end else if (do_enq && (occupancy_reg == CNT_W'(i))) begin
                entries_next[i] = elem_in;
            end
        end
    end

    always_comb begin
        occupancy_next = occupancy_reg;
        if (do_enq) begin
            occupancy_next = occupancy_reg + 1'b1;
        end else if (do_remove) begin
            occupancy_next = occupancy_reg - 1'b1;
        end
    end

    assign head_ext  = 64'(signed'(entries_next[0]));
    assign head_next = (occupancy_next == '0) ? '0 : head_ext[VALUE_W-1:0];

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < DEPTH; i++) begin
                entries_reg[i] <= entries_next[i];
            end
            head_reg   <= head_next;
            count_reg  <= occupancy_next;
            empty_reg  <= (occupancy_next == '0);
            status_reg <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occupancy_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                occupancy_reg <= occupancy_next;
            end
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_head_value = head_reg;
    assign m_count      = count_reg;
    assign m_is_empty   = empty_reg;
    assign m_status     = status_reg;

endmodule

// ===== sv/fwr_checker.sv =====
// ----------------------------------------------------------------------------
// fwr_checker
// port-level checks of the fifo with removal at an index
// ----------------------------------------------------------------------------
module fwr_checker #(
    parameter int DEPTH = fwr_pkg::DEPTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic signed [fwr_pkg::VALUE_W-1:0]   m_head_value,
    input  logic [$clog2(DEPTH+1)-1:0]           m_count,
    input  logic                                 m_is_empty,
    input  fwr_pkg::status_t                     m_status
);
    import fwr_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    // one request in gives one result on the next cycle
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted request produced no result");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_is_empty == (m_count == '0)))
        else $error("empty flag disagrees with count");

    a_empty_head: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_empty |-> (m_head_value == '0))
        else $error("head not zero on empty queue");

    a_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_count <= CNT_W'(DEPTH)))
        else $error("count above depth");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_count) && $stable(m_status))
        else $error("stalled result changed");

endmodule

bind fifo_with_remove_at_index fwr_checker #(.DEPTH(DEPTH)) u_fwr_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_head_value (m_head_value),
    .m_count      (m_count),
    .m_is_empty   (m_is_empty),
    .m_status     (m_status)
);
